FILE: rtl/waveform_table_sample_generator_macros.svh
// Assertion shorthands used by the checker of this block.
`ifndef WAVEFORM_TABLE_SAMPLE_GENERATOR_MACROS_SVH
`define WAVEFORM_TABLE_SAMPLE_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WTSG_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WTSG_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wtsg_pkg.sv
package wtsg_pkg;

    localparam int unsigned MaxCodeDefault = 4095;
    localparam int IdxW        = 16;
    localparam int CodeW       = 12;
    localparam int LevelW      = 13;
    localparam int DivSteps    = 16;
    localparam int CordicSteps = 16;
    localparam int CordW       = 33;
    localparam int AngW        = 20;

    localparam logic signed [CordW-1:0] CordicGain = 33'sd652032874;

    localparam logic [1:0]  ShapeReset  = 2'd0;
    localparam logic [11:0] OffsetReset = 12'd2048;
    localparam logic [11:0] AmpReset    = 12'd2047;
    localparam logic [15:0] LengthReset = 16'd256;

    localparam logic [7:0] REG_SHAPE     = 8'd0;
    localparam logic [7:0] REG_OFFSET    = 8'd1;
    localparam logic [7:0] REG_AMPLITUDE = 8'd2;
    localparam logic [7:0] REG_LENGTH    = 8'd3;

    typedef enum logic [1:0] {
        SHAPE_SINE     = 2'd0,
        SHAPE_SQUARE   = 2'd1,
        SHAPE_TRIANGLE = 2'd2,
        SHAPE_SAWTOOTH = 2'd3
    } t_shape;

    typedef struct packed {
        t_shape shape;
        logic   err;
        logic   zero;
        logic   fall;
        logic   first_half;
    } t_side;

    typedef struct packed {
        t_side       side;
        logic [15:0] quot;
    } t_tail;

    // Arctangent of 2^-k, 2^20 per turn.
    function automatic logic signed [AngW-1:0] atan_step(input int k);
        logic signed [AngW-1:0] a;
        case (k)
            0:       a = 20'sd131072;
            1:       a = 20'sd77376;
            2:       a = 20'sd40884;
            3:       a = 20'sd20753;
            4:       a = 20'sd10417;
            5:       a = 20'sd5213;
            6:       a = 20'sd2607;
            7:       a = 20'sd1304;
            8:       a = 20'sd652;
            9:       a = 20'sd326;
            10:      a = 20'sd163;
            11:      a = 20'sd81;
            12:      a = 20'sd41;
            13:      a = 20'sd20;
            14:      a = 20'sd10;
            default: a = 20'sd5;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/wtsg_divider.sv
module wtsg_divider
    import wtsg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_num,
    input  logic [15:0] i_den,
    input  t_side       i_side,
    output logic        o_valid,
    output logic [15:0] o_quot,
    output t_side       o_side
);

    logic        w_v    [0:DivSteps];
    logic [15:0] w_rem  [0:DivSteps];
    logic [15:0] w_low  [0:DivSteps];
    logic [15:0] w_q    [0:DivSteps];
    logic [15:0] w_den  [0:DivSteps];
    t_side       w_side [0:DivSteps];

    // High half of the numerator is below the divisor, so the quotient fits 16 bits.
    assign w_v[0]    = i_valid;
    assign w_rem[0]  = i_num[31:16];
    assign w_low[0]  = i_num[15:0];
    assign w_q[0]    = '0;
    assign w_den[0]  = i_den;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < DivSteps; k++) begin : g_step
        logic        r_v;
        logic [15:0] r_rem, r_low, r_q, r_den;
        t_side       r_side;
        logic [16:0] n_trial;
        logic [16:0] n_diff;
        logic        n_ge;

        assign n_trial = {w_rem[k], w_low[k][15]};
        assign n_ge    = n_trial >= {1'b0, w_den[k]};
        assign n_diff  = n_trial - {1'b0, w_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_ge ? n_diff[15:0] : n_trial[15:0];
                r_low  <= {w_low[k][14:0], 1'b0};
                r_q    <= {w_q[k][14:0], n_ge};
                r_den  <= w_den[k];
                r_side <= w_side[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_rem[k+1]  = r_rem;
        assign w_low[k+1]  = r_low;
        assign w_q[k+1]    = r_q;
        assign w_den[k+1]  = r_den;
        assign w_side[k+1] = r_side;
    end

    assign o_valid = w_v[DivSteps];
    assign o_quot  = w_q[DivSteps];
    assign o_side  = w_side[DivSteps];

endmodule

FILE: rtl/wtsg_cordic.sv
module wtsg_cordic
    import wtsg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  t_tail                   i_tail,
    output logic                    o_valid,
    output logic signed [CordW-1:0] o_x,
    output logic signed [CordW-1:0] o_y,
    output t_tail                   o_tail
);

    logic                   w_v    [0:CordicSteps];
    logic signed [CordW-1:0] w_x   [0:CordicSteps];
    logic signed [CordW-1:0] w_y   [0:CordicSteps];
    logic signed [AngW-1:0]  w_z   [0:CordicSteps];
    t_tail                  w_tail [0:CordicSteps];

    // Rotate within the quadrant; the quadrant itself is applied downstream.
    assign w_v[0]    = i_valid;
    assign w_x[0]    = CordicGain;
    assign w_y[0]    = '0;
    assign w_z[0]    = $signed({2'b00, i_tail.quot[13:0], 4'b0000});
    assign w_tail[0] = i_tail;

    for (genvar k = 0; k < CordicSteps; k++) begin : g_step
        logic                    r_v;
        logic signed [CordW-1:0] r_x, r_y;
        logic signed [AngW-1:0]  r_z;
        t_tail                   r_tail;
        logic signed [CordW-1:0] n_dx, n_dy;

        assign n_dx = w_y[k] >>> k;
        assign n_dy = w_x[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_z[k][AngW-1]) begin
                    r_x <= w_x[k] - n_dx;
                    r_y <= w_y[k] + n_dy;
                    r_z <= w_z[k] - atan_step(k);
                end else begin
                    r_x <= w_x[k] + n_dx;
                    r_y <= w_y[k] - n_dy;
                    r_z <= w_z[k] + atan_step(k);
                end
                r_tail <= w_tail[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_x[k+1]    = r_x;
        assign w_y[k+1]    = r_y;
        assign w_z[k+1]    = r_z;
        assign w_tail[k+1] = r_tail;
    end

    assign o_valid = w_v[CordicSteps];
    assign o_x     = w_x[CordicSteps];
    assign o_y     = w_y[CordicSteps];
    assign o_tail  = w_tail[CordicSteps];

endmodule

FILE: rtl/waveform_table_sample_generator.sv
// Waveform table sample generator: each stream transaction carries a sample
// index and returns the DAC code at that index of one period of a sine,
// square, triangle or sawtooth of period_length samples, built around
// level_offset with swing_amplitude and clamped to 0..MAX_CODE. An index at or
// beyond the period length returns code 0 with the error flag in tuser set.
// The block takes one sample per clock and is fully pipelined: two front
// stages (range check and operand select, then the span multiply), sixteen
// divider stages, sixteen CORDIC stages and three back stages (sine rounding,
// amplitude multiply, level assembly into the output register). The whole
// pipeline holds while the output register is full and not taken, so tready
// falls during a stall. Registers are written through the cfg channel, which
// is always ready; write them only while no sample is in flight.
module waveform_table_sample_generator
    import wtsg_pkg::*;
#(
    parameter int unsigned MAX_CODE = MaxCodeDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // cfg write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] sample_index
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [11:0] sample_code, [15:12] zero
    output logic [0:0]  o_m_tuser    // [0] index_error
);

    localparam logic [16:0] MaxC = 17'(MAX_CODE);

    // Configuration registers.
    t_shape      r_shape;
    logic [11:0] r_offset, r_amp;
    logic [15:0] r_len;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape  <= t_shape'(ShapeReset);
            r_offset <= OffsetReset;
            r_amp    <= AmpReset;
            r_len    <= LengthReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SHAPE:     r_shape  <= t_shape'(i_cfg_data[1:0]);
                REG_OFFSET:    r_offset <= i_cfg_data[11:0];
                REG_AMPLITUDE: r_amp    <= i_cfg_data[11:0];
                REG_LENGTH:    r_len    <= i_cfg_data;
                default: ; // drop writes to unknown registers
            endcase
        end
    end

    // Low and high levels, both clamped to the code range.
    logic [12:0]        w_sum;
    logic signed [13:0] w_diff;
    logic [16:0]        w_lo, w_hi;
    logic [16:0]        w_span;

    always_comb begin
        w_sum  = {1'b0, r_offset} + {1'b0, r_amp};
        w_diff = $signed({2'b00, r_offset}) - $signed({2'b00, r_amp});
        if (w_diff[13]) begin
            w_lo = '0;
        end else if ({4'b0, w_diff[12:0]} > MaxC) begin
            w_lo = MaxC;
        end else begin
            w_lo = {4'b0, w_diff[12:0]};
        end
        w_hi   = ({4'b0, w_sum} > MaxC) ? MaxC : {4'b0, w_sum};
        w_span = w_hi - w_lo;
    end

    // Advance every stage only when the output register can take a result.
    logic w_en;
    logic r_out_v;

    assign w_en       = !r_out_v || i_m_tready;
    assign o_s_tready = w_en;

    // Stage 1: range check, half-period compare, operand and divisor select.
    logic        r1_v;
    logic [15:0] r1_x, r1_den;
    t_side       r1_side;

    logic [15:0] w_idx, w_half;
    logic [15:0] n1_x, n1_den;
    t_side       n1_side;

    always_comb begin
        w_idx  = i_s_tdata;
        w_half = {1'b0, r_len[15:1]};
        n1_side.shape      = r_shape;
        n1_side.err        = w_idx >= r_len;
        n1_side.first_half = w_idx < w_half;
        n1_side.fall       = 1'b0;
        n1_side.zero       = 1'b0;
        n1_x               = w_idx;
        n1_den             = r_len;
        case (r_shape)
            SHAPE_TRIANGLE: begin
                n1_den       = w_half - 16'd1;
                n1_side.zero = w_half <= 16'd1;
                if (!n1_side.first_half) begin
                    n1_x         = w_idx - w_half;
                    n1_side.fall = 1'b1;
                end
            end
            SHAPE_SAWTOOTH: begin
                n1_den       = r_len - 16'd1;
                n1_side.zero = r_len <= 16'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x    <= n1_x;
            r1_den  <= n1_den;
            r1_side <= n1_side;
        end
    end

    // Stage 2: numerator is index times 2^16 for sine, span times ramp position else.
    logic        r2_v;
    logic [31:0] r2_num;
    logic [15:0] r2_den;
    t_side       r2_side;
    logic [28:0] w_prod;

    assign w_prod = w_span[12:0] * r1_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_num  <= (r1_side.shape == SHAPE_SINE) ? {r1_x, 16'b0} : {3'b0, w_prod};
            r2_den  <= r1_den;
            r2_side <= r1_side;
        end
    end

    // Divider: quotient is the phase for sine, the ramp step otherwise.
    logic        w_div_v;
    logic [15:0] w_quot;
    t_side       w_div_side;
    t_tail       w_div_tail;

    wtsg_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_v),
        .i_num   (r2_num),
        .i_den   (r2_den),
        .i_side  (r2_side),
        .o_valid (w_div_v),
        .o_quot  (w_quot),
        .o_side  (w_div_side)
    );

    assign w_div_tail.side = w_div_side;
    assign w_div_tail.quot = w_quot;

    logic                    w_cor_v;
    logic signed [CordW-1:0] w_cx, w_cy;
    t_tail                   w_cor_tail;

    wtsg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_v),
        .i_tail  (w_div_tail),
        .o_valid (w_cor_v),
        .o_x     (w_cx),
        .o_y     (w_cy),
        .o_tail  (w_cor_tail)
    );

    // Back stage 1: apply the quadrant, round to Q1.15 and saturate.
    logic                r3_v;
    logic signed [16:0]  r3_w;
    t_tail               r3_tail;
    logic signed [CordW:0] n3_v, n3_r;
    logic signed [18:0]  n3_s;
    logic signed [16:0]  n3_w;

    always_comb begin
        case (w_cor_tail.quot[15:14])
            2'd0:    n3_v = {w_cy[CordW-1], w_cy};
            2'd1:    n3_v = {w_cx[CordW-1], w_cx};
            2'd2:    n3_v = -{w_cy[CordW-1], w_cy};
            default: n3_v = -{w_cx[CordW-1], w_cx};
        endcase
        n3_r = n3_v + 34'sd16384;
        n3_s = n3_r[33:15];
        if (n3_s > 19'sd32767) begin
            n3_w = 17'sd32767;
        end else if (n3_s < -19'sd32767) begin
            n3_w = -17'sd32767;
        end else begin
            n3_w = n3_s[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= w_cor_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_w    <= n3_w;
            r3_tail <= w_cor_tail;
        end
    end

    // Back stage 2: amplitude times sine.
    logic               r4_v;
    logic signed [29:0] r4_prod;
    t_tail              r4_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_prod <= $signed({1'b0, r_amp}) * r3_w;
            r4_tail <= r3_tail;
        end
    end

    // Back stage 3: assemble the level for the shape, into the output register.
    logic [CodeW-1:0]   r_code;
    logic               r_err;
    logic signed [31:0] n5_acc, n5_sh;
    logic signed [17:0] n5_fall;
    logic [16:0]        n5_code;

    always_comb begin
        n5_acc  = $signed({5'b0, r_offset, 15'b0}) + 32'(r4_prod) + 32'sd16384;
        n5_sh   = n5_acc >>> 15;
        n5_fall = $signed({1'b0, w_hi}) - $signed({2'b0, r4_tail.quot});
        case (r4_tail.side.shape)
            SHAPE_SINE: begin
                if (n5_sh[31]) begin
                    n5_code = '0;
                end else if (n5_sh[30:0] > 31'(MaxC)) begin
                    n5_code = MaxC;
                end else begin
                    n5_code = n5_sh[16:0];
                end
            end
            SHAPE_SQUARE: begin
                n5_code = r4_tail.side.first_half ? w_hi : w_lo;
            end
            SHAPE_TRIANGLE: begin
                if (r4_tail.side.zero) begin
                    n5_code = w_lo;
                end else if (!r4_tail.side.fall) begin
                    n5_code = w_lo + {1'b0, r4_tail.quot};
                end else if (n5_fall < $signed({1'b0, w_lo})) begin
                    n5_code = w_lo; // odd-length tail undershoots
                end else begin
                    n5_code = n5_fall[16:0];
                end
            end
            default: begin
                n5_code = r4_tail.side.zero ? w_lo : w_lo + {1'b0, r4_tail.quot};
            end
        endcase
        if (r4_tail.side.err) begin
            n5_code = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_code <= n5_code[CodeW-1:0];
            r_err  <= r4_tail.side.err;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {4'b0, r_code};
    assign o_m_tuser  = r_err;

endmodule

FILE: rtl/wtsg_checker.sv
`include "waveform_table_sample_generator_macros.svh"

module wtsg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [0:0]  o_m_tuser
);

    // An out-of-range index always reports code zero.
    `WTSG_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tdata[11:0] == 12'd0, "error result with nonzero code")

    // Padding above the code stays clear.
    `WTSG_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[15:12] == 4'd0, "tdata padding not zero")

    // A stalled result holds.
    `WTSG_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result changed")

    // The pipeline freezes while the output is stalled, so no input is taken.
    `WTSG_ASSERT_IMP(a_stall_blocks, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, !o_s_tready, "input ready during output stall")

endmodule

bind waveform_table_sample_generator wtsg_checker u_wtsg_checker (.*);
